/* sv/slp_pkg.sv */
// Package for the standardised linear predictor.
// Holds the word types, register indexes, fixed constants and the root table.
// No dependencies.
`default_nettype none
package slp_pkg;

   // Input word: a table load or one feature of a set.
   typedef struct packed {
      logic               kind;
      logic [5:0]         slot;
      logic signed [31:0] feature_value;
      logic signed [31:0] mean_value;
      logic signed [31:0] inverse_scale;
      logic signed [31:0] weight;
      logic               last;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [47:0] prediction;
      logic        outlier;
      logic        saturated;
   } rsp_type;

   // One row of the coefficient memory.
   typedef struct packed {
      logic signed [31:0] mean_value;
      logic signed [31:0] inverse_scale;
      logic signed [31:0] weight;
   } entry_type;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_INTERCEPT     = 2'd0;
   localparam logic [1:0] CSR_OUTLIER_LIMIT = 2'd1;
   localparam logic [1:0] CSR_STD_COUNT     = 2'd2;

   // Word kinds.
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_FEATURE = 1'b1;

   localparam int            OUTLIER_DEFAULT = 6;
   localparam int            EXP_CLAMP       = 10;
   localparam logic [31:0]   LOG2_TEN_Q30    = 32'd3566893132;
   localparam int            ROOT_STEPS      = 30;

   typedef logic [31:0] root_table_type [0:31];

   // Integer square root, used only while the root table is built.
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_w;
      logic [63:0] rem;
      res   = 64'd0;
      bit_w = 64'd1 << 62;
      rem   = v;
      while (bit_w > rem) begin
         bit_w = bit_w >> 2;
      end
      while (bit_w != 64'd0) begin
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Entry k holds 2^(2^-k) in Q2.30, each the floored root of the one before.
   function automatic root_table_type build_roots();
      root_table_type t;
      logic [63:0]    r;
      r = 64'd1 << 31;
      for (int k = 0; k < 32; k++) begin
         t[k] = 32'd0;
      end
      t[0] = r[31:0];
      for (int k = 1; k <= ROOT_STEPS; k++) begin
         r    = isqrt64(r << 30);
         t[k] = r[31:0];
      end
      return t;
   endfunction

   localparam root_table_type ROOTS = build_roots();

endpackage
`default_nettype wire

/* sv/slp_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on nothing but its operands.
`default_nettype none
module slp_mul (
   input  wire logic               clock,
   input  wire logic signed [33:0] op_a,
   input  wire logic signed [33:0] op_b,
   output logic signed [67:0]      prod_ff
);

   logic signed [67:0] prod_in;

   // One product per cycle, registered before any use.
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

/* sv/slp_table.sv */
// Coefficient memory: mean, reciprocal scale and weight for each feature.
// Uses slp_pkg for the row type. One write port, one registered read port.
`default_nettype none
module slp_table
   import slp_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output entry_type              rd_data_ff
);

   entry_type mem [0:DEPTH-1];

   // Write on load words only.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read every cycle at the current position.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* sv/standardised_linear_predictor_top.sv */
// Standardised linear predictor, top level.
// Uses slp_pkg, slp_mul and slp_table.
//
// Load words (kind 0) write one row of the coefficient memory.
// Feature words (kind 1) are counted by a position counter; the leading
// standardised_count features are standardised as (x - mean) * inv_scale and
// checked against the outlier limit, then every feature within the table depth is
// weighted and added with saturation onto the intercept. A standardised feature
// word goes through a memory read, two passes through the single shared multiplier,
// a compare and the accumulate; a raw feature skips the first pass and the compare.
// The last feature of a set then runs 10^sum as 2^(sum * log2 10) on the same
// multiplier: one product for the exponent, a split step, then a loop step per
// fraction bit with a further multiply step per set bit, a scale step and an output
// step. The input is stalled throughout; the result register lets the next set start
// while a result waits. An outlier set skips the exponential and returns zero.
`default_nettype none
module standardised_linear_predictor_top
   import slp_pkg::*;
#(
   parameter int MAX_FEATURES  = 64,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int POS_W  = $clog2(MAX_FEATURES + 1);
   localparam int FB     = FRACTION_BITS + 30;
   localparam int SUM_W  = 70;
   localparam logic signed [47:0] EXP_LIM = 48'(EXP_CLAMP) <<< FRACTION_BITS;
   localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_STD   = 4'd1;
   localparam logic [3:0] S_CHK   = 4'd2;
   localparam logic [3:0] S_TERM  = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_EXPY  = 4'd5;
   localparam logic [3:0] S_SPLIT = 4'd6;
   localparam logic [3:0] S_LOOP  = 4'd7;
   localparam logic [3:0] S_PMUL  = 4'd8;
   localparam logic [3:0] S_SCALE = 4'd9;
   localparam logic [3:0] S_EMIT  = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic signed [31:0] intercept_ff, intercept_in;
   logic [30:0]        limit_ff, limit_in;
   logic [6:0]         std_count_ff, std_count_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               outlier_ff, outlier_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [31:0] x_ff, x_in;
   logic               last_ff, last_in;
   logic signed [31:0] v_ff, v_in;
   logic signed [8:0]  e_ff, e_in;
   logic [29:0]        f30_ff, f30_in;
   logic [31:0]        p_ff, p_in;
   logic [4:0]         k_ff, k_in;
   logic [47:0]        pred_ff, pred_in;
   logic               sat_ff, sat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               out_free;
   logic               pos_in_range;
   logic               pos_std;
   logic signed [33:0] op_a, op_b;
   logic signed [67:0] prod_ff;
   entry_type          entry_ff;
   entry_type          load_entry;
   logic               load_en;
   logic signed [32:0] diff;
   logic signed [67:0] z_wide;
   logic               z_out;
   logic signed [31:0] z_clamped;
   logic signed [SUM_W-1:0] sum_wide;
   logic signed [47:0] acc_sat;
   logic signed [47:0] s_clamped;
   logic signed [8:0]  shift;
   logic [8:0]         shift_neg;
   logic [63:0]        scaled;
   logic               root_bit;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign pos_in_range = (32'(pos_ff) < MAX_FEATURES);
   assign pos_std      = (32'(pos_ff) < 32'(std_count_ff));

   // Coefficient memory, written by load words within range.
   assign load_en = req_accept && (req_data.kind == KIND_LOAD)
                    && (32'(req_data.slot) < MAX_FEATURES);
   assign load_entry.mean_value    = req_data.mean_value;
   assign load_entry.inverse_scale = req_data.inverse_scale;
   assign load_entry.weight        = req_data.weight;

   slp_table #(
      .DEPTH  (MAX_FEATURES),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock      (clock),
      .wr_en      (load_en),
      .wr_addr    (ADDR_W'(req_data.slot)),
      .wr_data    (load_entry),
      .rd_addr    (pos_ff[ADDR_W-1:0]),
      .rd_data_ff (entry_ff)
   );

   // Operand selection for the shared multiplier.
   assign diff = $signed({x_ff[31], x_ff}) - $signed({entry_ff.mean_value[31],
                                                      entry_ff.mean_value});
   assign s_clamped = (acc_ff > EXP_LIM) ? EXP_LIM :
                      ((acc_ff < -EXP_LIM) ? -EXP_LIM : acc_ff);
   assign root_bit  = f30_ff[5'(30 - k_ff)];

   always_comb begin
      op_a = 34'sd0;
      op_b = 34'sd0;
      case (state_ff)
         S_STD: begin
            op_a = 34'(diff);
            op_b = 34'(entry_ff.inverse_scale);
         end
         S_TERM: begin
            op_a = 34'(v_ff);
            op_b = 34'(entry_ff.weight);
         end
         S_EXPY: begin
            op_a = 34'(s_clamped);
            op_b = $signed({2'b00, LOG2_TEN_Q30});
         end
         S_LOOP: begin
            op_a = $signed({2'b00, p_ff});
            op_b = $signed({2'b00, ROOTS[k_ff]});
         end
         default: begin
            op_a = 34'sd0;
            op_b = 34'sd0;
         end
      endcase
   end

   slp_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   // Standardised value, outlier test and clamp to 32 bits.
   assign z_wide = prod_ff >>> FRACTION_BITS;
   assign z_out  = (z_wide > $signed({37'd0, limit_ff}))
                   || (z_wide < -$signed({37'd0, limit_ff}));
   assign z_clamped = (z_wide > 68'sd2147483647) ? 32'sh7FFFFFFF :
                      ((z_wide < -68'sd2147483648) ? 32'sh80000000 : z_wide[31:0]);

   // Saturating accumulation of the weighted term.
   assign sum_wide = SUM_W'(acc_ff) + SUM_W'(prod_ff >>> FRACTION_BITS);
   assign acc_sat  = (sum_wide > SUM_W'(ACC_MAX)) ? ACC_MAX :
                     ((sum_wide < SUM_W'(ACC_MIN)) ? ACC_MIN : sum_wide[47:0]);

   // Final scaling of 2^frac by the integer exponent.
   assign shift     = e_ff + 9'(FRACTION_BITS) - 9'sd30;
   assign shift_neg = 9'(-shift);
   always_comb begin
      if (shift >= 0) begin
         scaled = 64'(p_ff) << shift[5:0];
      end else begin
         scaled = 64'(p_ff) >> shift_neg;
      end
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      outlier_in = outlier_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      last_in   = last_ff;
      v_in      = v_ff;
      e_in      = e_ff;
      f30_in    = f30_ff;
      p_in      = p_ff;
      k_in      = k_ff;
      pred_in   = pred_ff;
      sat_in    = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_data.kind == KIND_FEATURE)) begin
               x_in    = req_data.feature_value;
               v_in    = req_data.feature_value;
               last_in = req_data.last;
               if (pos_ff == '0) begin
                  acc_in = 48'(intercept_ff);
               end
               if (pos_in_range) begin
                  state_in = pos_std ? S_STD : S_TERM;
               end else if (req_data.last) begin
                  state_in = outlier_ff ? S_EMIT : S_EXPY;
               end
            end
         end
         S_STD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (z_out) begin
               outlier_in = 1'b1;
            end
            v_in     = z_clamped;
            state_in = S_TERM;
         end
         S_TERM: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_sat;
            pos_in = pos_ff + 1'b1;
            if (last_ff) begin
               state_in = outlier_ff ? S_EMIT : S_EXPY;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EXPY: begin
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            e_in     = 9'(prod_ff >>> FB);
            f30_in   = prod_ff[FRACTION_BITS+29:FRACTION_BITS];
            p_in     = 32'd1 << 30;
            k_in     = 5'd1;
            state_in = S_LOOP;
         end
         S_LOOP: begin
            if (root_bit) begin
               state_in = S_PMUL;
            end else if (k_ff == 5'(ROOT_STEPS)) begin
               state_in = S_SCALE;
            end else begin
               k_in = k_ff + 5'd1;
            end
         end
         S_PMUL: begin
            p_in = prod_ff[61:30];
            if (k_ff == 5'(ROOT_STEPS)) begin
               state_in = S_SCALE;
            end else begin
               k_in     = k_ff + 5'd1;
               state_in = S_LOOP;
            end
         end
         S_SCALE: begin
            sat_in   = |scaled[63:48];
            pred_in  = (|scaled[63:48]) ? {48{1'b1}} : scaled[47:0];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.prediction = outlier_ff ? 48'd0 : pred_ff;
               rsp_data_in.outlier    = outlier_ff;
               rsp_data_in.saturated  = outlier_ff ? 1'b0 : sat_ff;
               outlier_in = 1'b0;
               pos_in     = '0;
               acc_in     = 48'(intercept_ff);
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      intercept_in = intercept_ff;
      limit_in     = limit_ff;
      std_count_in = std_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INTERCEPT:     intercept_in = csr_data;
            CSR_OUTLIER_LIMIT: limit_in     = csr_data[30:0];
            CSR_STD_COUNT:     std_count_in = csr_data[6:0];
            default:           intercept_in = intercept_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         outlier_ff   <= 1'b0;
         acc_ff       <= 48'sd0;
         rsp_valid_ff <= 1'b0;
         intercept_ff <= 32'sd0;
         limit_ff     <= 31'(OUTLIER_DEFAULT) << FRACTION_BITS;
         std_count_ff <= 7'd0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         outlier_ff   <= outlier_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         intercept_ff <= intercept_in;
         limit_ff     <= limit_in;
         std_count_ff <= std_count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      last_ff     <= last_in;
      v_ff        <= v_in;
      e_ff        <= e_in;
      f30_ff      <= f30_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      pred_ff     <= pred_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

/* tb/standardised_linear_predictor_top_test.sv */
// Self-checking test for the standardised linear predictor top level.
// Depends on slp_pkg and standardised_linear_predictor_top only; an in-bench
// model predicts each prediction word and a scoreboard class checks them in order.
`default_nettype none
module standardised_linear_predictor_top_test;
   import slp_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam longint SUM_MAX = 64'sd140737488355327;
   localparam longint SUM_MIN = -64'sd140737488355328;
   localparam logic [47:0] PREDICTION_MAX = 48'hFFFF_FFFF_FFFF;

   // Prediction model and in-order comparison of prediction words.
   class prediction_scoreboard;
      logic signed [31:0] means [TABLE_DEPTH];
      logic signed [31:0] inv_scales [TABLE_DEPTH];
      logic signed [31:0] weights [TABLE_DEPTH];
      logic [63:0]        roots [31];
      longint             intercept_reg;
      longint             limit_reg;
      int                 std_count_reg;
      longint             running_sum;
      bit                 outlier_flag;
      int                 position;
      rsp_type            pending [$];
      int                 mismatches;
      int                 predictions_checked;
      int                 sets_seen;
      int                 outliers_seen;
      int                 saturations_seen;

      function new();
         logic [63:0] r;
         intercept_reg = 0;
         limit_reg = longint'(OUTLIER_DEFAULT) <<< 16;
         std_count_reg = 0;
         running_sum = 0;
         outlier_flag = 0;
         position = 0;
         mismatches = 0;
         predictions_checked = 0;
         sets_seen = 0;
         outliers_seen = 0;
         saturations_seen = 0;
         // Chain of square roots of two, each floored in Q2.30.
         r = 64'd1 << 31;
         roots[0] = r;
         for (int k = 1; k <= 30; k++) begin
            r = root_floor(r << 30);
            roots[k] = r;
         end
      endfunction

      function logic [63:0] root_floor(logic [63:0] v);
         logic [63:0] acc;
         logic [63:0] trial;
         acc = 0;
         for (int b = 31; b >= 0; b--) begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= v) begin
               acc = trial;
            end
         end
         return acc;
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            CSR_INTERCEPT: begin
               intercept_reg = longint'($signed(value));
            end
            CSR_OUTLIER_LIMIT: begin
               limit_reg = longint'(value[30:0]);
            end
            CSR_STD_COUNT: begin
               std_count_reg = int'(value[6:0]);
            end
            default: begin
            end
         endcase
      endfunction

      // 10^s as 2^(s * log2 10), in unsigned Q32.16 with saturation.
      function logic [47:0] ten_power(longint s, output bit sat);
         longint      lim;
         longint      y;
         longint      e;
         longint      sh;
         logic [63:0] u;
         logic [63:0] f30;
         logic [63:0] p;
         logic [63:0] val;
         lim = longint'(EXP_CLAMP) <<< 16;
         if (s > lim) s = lim;
         if (s < -lim) s = -lim;
         y = s * longint'({32'd0, LOG2_TEN_Q30});
         u = y + (64'sd64 <<< 46);
         e = longint'(u >> 46) - 64;
         f30 = (u >> 16) & ((64'd1 << 30) - 1);
         p = 64'd1 << 30;
         for (int k = 1; k <= 30; k++) begin
            if (f30[30 - k]) begin
               p = (p * roots[k]) >> 30;
            end
         end
         sh = e + 16 - 30;
         if (sh >= 0) val = p << sh;
         else if (-sh >= 64) val = 0;
         else val = p >> (-sh);
         sat = 0;
         if (val > {16'd0, PREDICTION_MAX}) begin
            val = {16'd0, PREDICTION_MAX};
            sat = 1;
         end
         return val[47:0];
      endfunction

      // Updates the model for one accepted input word.
      function void note_word(req_type w);
         logic signed [127:0] wide;
         longint              v;
         longint              term;
         bit                  sat;
         rsp_type             res;
         if (w.kind == KIND_LOAD) begin
            means[w.slot] = w.mean_value;
            inv_scales[w.slot] = w.inverse_scale;
            weights[w.slot] = w.weight;
            return;
         end
         if (position == 0) running_sum = intercept_reg;
         if (position < TABLE_DEPTH) begin
            v = longint'(w.feature_value);
            if (position < std_count_reg) begin
               wide = (128'(w.feature_value) - 128'(means[position]))
                      * 128'(inv_scales[position]);
               wide = wide >>> 16;
               if (wide > 128'(limit_reg) || wide < -128'(limit_reg)) outlier_flag = 1;
               if (wide > 128'sd2147483647) wide = 128'sd2147483647;
               if (wide < -128'sd2147483648) wide = -128'sd2147483648;
               v = longint'(wide);
            end
            term = (v * longint'(weights[position])) >>> 16;
            running_sum = running_sum + term;
            if (running_sum > SUM_MAX) running_sum = SUM_MAX;
            if (running_sum < SUM_MIN) running_sum = SUM_MIN;
            position++;
         end
         if (!w.last) return;
         res.prediction = 0;
         res.saturated = 0;
         res.outlier = outlier_flag;
         if (!outlier_flag) begin
            res.prediction = ten_power(running_sum, sat);
            res.saturated = sat;
         end
         pending.push_back(res);
         sets_seen++;
         if (res.outlier) outliers_seen++;
         if (res.saturated) saturations_seen++;
         running_sum = intercept_reg;
         outlier_flag = 0;
         position = 0;
      endfunction

      // Compares one accepted prediction word with the oldest expectation.
      function void check_word(rsp_type got);
         rsp_type want;
         predictions_checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected prediction word %h", got);
            end
            return;
         end
         want = pending.pop_front();
         if (got.prediction !== want.prediction || got.outlier !== want.outlier
             || got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: prediction %h outlier %b saturated %b, expected %h %b %b",
                        got.prediction, got.outlier, got.saturated,
                        want.prediction, want.outlier, want.saturated);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   prediction_scoreboard board;
   int                   words_sent;
   bit                   stimulus_done;

   standardised_linear_predictor_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Clock with a period of two units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Q16.16 value: mostly within a few units, sometimes any 32-bit pattern.
   function automatic logic [31:0] q_value(int units);
      if ($urandom_range(0, 99) < 90) begin
         return $urandom_range(0, 2 * units * 65536) - units * 65536;
      end
      return $urandom;
   endfunction

   // Sends one word, holding it until the block takes it.
   task automatic send_word(req_type w);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_data = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = w;
      do @(posedge clock); while (req_stall);
      board.note_word(w);
      words_sent++;
   endtask

   task automatic load_row(int slot, logic [31:0] mean_v, logic [31:0] inv_v,
                           logic [31:0] weight_v, bit last_flag);
      req_type w;
      w = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      w.kind = KIND_LOAD;
      w.slot = slot[5:0];
      w.mean_value = mean_v;
      w.inverse_scale = inv_v;
      w.weight = weight_v;
      w.last = last_flag;
      send_word(w);
   endtask

   task automatic send_feature(logic [31:0] x, bit last_flag);
      req_type w;
      w = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      w.kind = KIND_FEATURE;
      w.feature_value = x;
      w.last = last_flag;
      send_word(w);
   endtask

   // One complete set of features, with stray table loads mixed in.
   task automatic send_set(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 6) begin
            load_row($urandom_range(0, 63), q_value(3), q_value(2), q_value(1),
                     1'($urandom_range(0, 1)));
         end
         send_feature(q_value(4), i == count - 1);
      end
   endtask

   // Drops the input valid, waits for every expected word, then lets the block settle.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Result side: stalls in bursts, with quiet stretches between.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = gap_length();
         if (hold > 0 && $urandom_range(0, 3) != 0) begin
            rsp_stall = 1'b1;
            repeat (hold - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_stall = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   end

   // Checks every accepted prediction word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_word(rsp_data);
      end
   end

   // Main sequence: fill the tables, directed sets, then random phases.
   initial begin
      logic [31:0] setting [3];
      board = new();
      words_sent = 0;
      stimulus_done = 0;
      reset = 1'b1;
      clock = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_INTERCEPT;
      csr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every slot is written before any feature reads it.
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         load_row(s, q_value(3), q_value(2), q_value(1), 1'b0);
      end

      // Directed: raw extremes, empty weight, load marked last.
      load_row(0, 32'h0, 32'h0001_0000, 32'h0, 1'b1);
      send_feature(32'h7FFF_FFFF, 1'b1);
      load_row(0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0);
      send_feature(32'h8000_0000, 1'b1);
      send_feature(32'h7FFF_FFFF, 1'b1);
      send_feature(32'h0000_8000, 1'b1);
      send_feature(32'h0, 1'b1);
      drain();

      // Standardised: zero inverse scale, then an outlier, then a limit of zero.
      write_reg(CSR_STD_COUNT, 32'd2);
      write_reg(CSR_INTERCEPT, 32'h0002_0000);
      load_row(1, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
      send_feature(32'h0003_0000, 1'b0);
      send_feature(32'h7FFF_FFFF, 1'b1);
      load_row(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
      send_feature(32'h0, 1'b0);
      send_feature(32'h7FFF_FFFF, 1'b1);
      drain();
      write_reg(CSR_OUTLIER_LIMIT, 32'h0);
      send_set(2);
      drain();

      // Intercept extremes: saturation high, underflow to zero.
      write_reg(CSR_STD_COUNT, 32'd0);
      write_reg(CSR_INTERCEPT, 32'h7FFF_FFFF);
      send_set(1);
      drain();
      write_reg(CSR_INTERCEPT, 32'h8000_0000);
      send_set(1);
      drain();

      // Random phases across several register settings.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: setting = '{32'h0, 32'h0006_0000, 32'd0};
            1: setting = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd64};
            2: setting = '{32'h8000_0000, 32'h0, 32'd64};
            3: setting = '{32'hFFFF_0000, 32'h0003_0000, 32'd3};
            default: setting = '{q_value(3), $urandom_range(0, 32'h000A_0000),
                                  $urandom_range(0, 64)};
         endcase
         write_reg(CSR_INTERCEPT, setting[0]);
         write_reg(CSR_OUTLIER_LIMIT, setting[1]);
         write_reg(CSR_STD_COUNT, setting[2]);
         for (int n = 0; n < 70; ) begin
            int len;
            len = ($urandom_range(0, 99) < 4) ? $urandom_range(60, 70)
                                              : $urandom_range(1, 8);
            send_set(len);
            n += len;
         end
         drain();
      end

      stimulus_done = 1;
      $display("Covered %0d words, %0d sets checked (%0d outliers, %0d saturated).",
               words_sent, board.predictions_checked, board.outliers_seen,
               board.saturations_seen);
      if (board.pending.size() != 0) board.mismatches += board.pending.size();
      $display("Mismatches counted: %0d.", board.mismatches);
      if (board.mismatches == 0) begin
         $display("standardised_linear_predictor_top verification clean");
      end else begin
         $display("standardised_linear_predictor_top verification failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #4000000;
      $display("standardised_linear_predictor_top verification failed");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
sv/slp_pkg.sv
sv/slp_mul.sv
sv/slp_table.sv
sv/standardised_linear_predictor_top.sv
tb/standardised_linear_predictor_top_test.sv
